>>> hw/rtl/xesc_pkg.sv
// Shared constants, types and the entity lookup of the XML escape encoder.
package xesc_pkg;

   localparam int LENGTH_BITS = 16;
   localparam int RUN_MAX = 6;
   localparam int IDX_BITS = $clog2(RUN_MAX);

   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_QUOT  = 8'h22;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

   typedef logic [0:RUN_MAX-1][7:0] seq_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] len;
      seq_type             seq;
   } entity_type;

   // One beat headed for the result register.
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
      logic       term;
   } beat_type;

   function automatic entity_type entity_lookup(input logic [7:0] b);
      entity_type e;
      e.len = IDX_BITS'(1);
      e.seq = {b, 40'h0};
      unique case (b)
         CHAR_AMP: begin
            e.len = IDX_BITS'(5);
            e.seq = {"&amp;", 8'h00};
         end
         CHAR_LT: begin
            e.len = IDX_BITS'(4);
            e.seq = {"&lt;", 16'h0000};
         end
         CHAR_GT: begin
            e.len = IDX_BITS'(4);
            e.seq = {"&gt;", 16'h0000};
         end
         CHAR_QUOT: begin
            e.len = IDX_BITS'(6);
            e.seq = "&quot;";
         end
         CHAR_TAB: begin
            e.len = IDX_BITS'(4);
            e.seq = {"&#9;", 16'h0000};
         end
         CHAR_LF: begin
            e.len = IDX_BITS'(5);
            e.seq = {"&#10;", 8'h00};
         end
         CHAR_CR: begin
            e.len = IDX_BITS'(5);
            e.seq = {"&#13;", 8'h00};
         end
         default: begin
            e.len = IDX_BITS'(1);
            e.seq = {b, 40'h0};
         end
      endcase
      return e;
   endfunction

endpackage

>>> hw/rtl/xml_escape_encoder_top.sv
// Top level of the XML escape encoder with its result register.
// An accepted byte passes the input register and then the result register to the output.
// Throughput: one result beat per cycle while not stalled; a plain character gives one beat,
// an escaped one 4 to 6 beats, as the single result register emits one byte per beat.
// Reset: synchronous active-high reset clears the sequencer, result valid and the
// length counter; no clearing pass is needed.
module xml_escape_encoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_string_end,
   output logic [15:0] rsp_escaped_length
);
   import xesc_pkg::*;

   beat_type    beat;
   logic        take;
   logic [15:0] length;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_last_ff;
   logic        rsp_end_ff;
   logic [15:0] rsp_len_ff;

   assign take = beat.valid && (!rsp_valid_ff || !rsp_stall);

   xesc_expand u_expand (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .take        (take),
      .beat        (beat)
   );

   xesc_count u_count (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .beat   (beat),
      .length (length)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take) begin
         rsp_byte_ff <= beat.data;
         rsp_last_ff <= beat.last;
         rsp_end_ff  <= beat.term;
         rsp_len_ff  <= beat.term ? length : 16'h0000;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = rsp_byte_ff;
   assign rsp_run_last       = rsp_last_ff;
   assign rsp_string_end     = rsp_end_ff;
   assign rsp_escaped_length = rsp_len_ff;

endmodule

>>> hw/rtl/xesc_expand.sv
// Input register and run sequencer: walks each character's escape run one byte per beat.
module xesc_expand (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_byte,
   input  logic               take,
   output xesc_pkg::beat_type beat
);
   import xesc_pkg::*;

   logic                cur_valid_ff, cur_valid_in;
   logic [7:0]          cur_byte_ff, cur_byte_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   entity_type          ent;
   logic                last;
   logic                load;

   assign ent  = entity_lookup(cur_byte_ff);
   assign last = (idx_ff == ent.len - IDX_BITS'(1));

   // The slot frees up in the same cycle its final byte moves out.
   assign req_stall = cur_valid_ff && !(take && last);
   assign load      = req_valid && !req_stall;

   assign beat.valid = cur_valid_ff;
   assign beat.data  = ent.seq[idx_ff];
   assign beat.last  = last;
   assign beat.term  = (cur_byte_ff == CHAR_NUL);

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_byte_in  = cur_byte_ff;
      idx_in       = idx_ff;
      if (take && !last) begin
         idx_in = idx_ff + IDX_BITS'(1);
      end else if (!cur_valid_ff || take) begin
         cur_valid_in = load;
         cur_byte_in  = req_in_byte;
         idx_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
      cur_byte_ff <= cur_byte_in;
   end

endmodule

>>> hw/rtl/xesc_count.sv
// Saturating count of escaped bytes in the current string.
module xesc_count (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  xesc_pkg::beat_type beat,
   output logic [15:0]        length
);
   import xesc_pkg::*;

   logic [LENGTH_BITS-1:0] count_ff, count_in;

   assign length = 16'(count_ff);

   always_comb begin
      count_in = count_ff;
      if (take) begin
         if (beat.term) begin
            count_in = '0;
         end else if (count_ff != LEN_MAX) begin
            count_in = count_ff + LENGTH_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

>>> hw/rtl/xesc_checker.sv
// Port-level checker for the XML escape encoder and its bind to the top level.
module xesc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_in_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_run_last,
   input logic        rsp_string_end,
   input logic [15:0] rsp_escaped_length
);

   // A terminator is always a single zero byte that closes its run.
   a_term_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_run_last && rsp_out_byte == 8'h00)
      else $error("terminator beat is malformed");

   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_string_end |-> rsp_escaped_length == 16'h0000)
      else $error("length reported on a non-terminator beat");

   // Inside an entity run no byte is zero and no terminator appears.
   a_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |-> rsp_out_byte != 8'h00 && !rsp_string_end)
      else $error("malformed beat in the middle of a run");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_run_last) && $stable(rsp_string_end)
         && $stable(rsp_escaped_length))
      else $error("stalled result beat changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_in_byte))
      else $error("stalled input beat changed");

endmodule

bind xml_escape_encoder_top xesc_checker u_xesc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_in_byte        (req_in_byte),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_out_byte       (rsp_out_byte),
   .rsp_run_last       (rsp_run_last),
   .rsp_string_end     (rsp_string_end),
   .rsp_escaped_length (rsp_escaped_length)
);

>>> test/xml_escape_encoder_top_tb.sv
// Self-checking testbench for the XML escape encoder: escaped runs, terminators and lengths.
`timescale 1ns / 1ps

module xml_escape_encoder_top_tb;
   import xesc_pkg::*;

   localparam int unsigned LENGTH_SAT = 32'((64'd1 << LENGTH_BITS) - 1);
   localparam int RANDOM_ITEMS = 250;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam longint CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        term;
      logic [15:0] length;
   } escaped_beat_type;

   // Escaping predictor and the queue of escaped beats still owed by the block.
   class escape_scoreboard_type;
      escaped_beat_type escaped_beats[$];
      int unsigned      string_count;
      int               errors;
      int               bytes_in;
      int               beats_checked;
      int               strings_done;

      task report(input string what, input logic [15:0] got, input logic [15:0] want);
         errors++;
         if (errors <= 20)
            $display("mismatch at beat %0d: %s got %0h, expected %0h",
                     beats_checked, what, got, want);
      endtask

      function void note_input(input logic [7:0] ch);
         string            txt;
         escaped_beat_type b;
         int               n;
         bytes_in++;
         if (ch == CHAR_NUL) begin
            b.data   = CHAR_NUL;
            b.last   = 1'b1;
            b.term   = 1'b1;
            b.length = string_count[15:0];
            escaped_beats.push_back(b);
            string_count = 0;
            return;
         end
         case (ch)
            CHAR_AMP:  txt = "&amp;";
            CHAR_LT:   txt = "&lt;";
            CHAR_GT:   txt = "&gt;";
            CHAR_QUOT: txt = "&quot;";
            CHAR_TAB:  txt = "&#9;";
            CHAR_LF:   txt = "&#10;";
            CHAR_CR:   txt = "&#13;";
            default:   txt = "";
         endcase
         n = (txt.len() == 0) ? 1 : txt.len();
         for (int k = 0; k < n; k++) begin
            b.data   = (txt.len() == 0) ? ch : txt[k];
            b.last   = (k == n - 1);
            b.term   = 1'b0;
            b.length = '0;
            escaped_beats.push_back(b);
         end
         // The length counter sticks at its maximum instead of wrapping.
         if (LENGTH_SAT - string_count < n)
            string_count = LENGTH_SAT;
         else
            string_count += n;
      endfunction

      task check_result(input logic [7:0] data, input logic last, input logic term,
                        input logic [15:0] length);
         escaped_beat_type want;
         beats_checked++;
         if (escaped_beats.size() == 0) begin
            report("beat with nothing pending, out_byte", 16'(data), '0);
            return;
         end
         want = escaped_beats.pop_front();
         if (data !== want.data) report("out_byte", 16'(data), 16'(want.data));
         if (last !== want.last) report("run_last", 16'(last), 16'(want.last));
         if (term !== want.term) report("string_end", 16'(term), 16'(want.term));
         if (length !== want.length) report("escaped_length", length, want.length);
         if (want.term) strings_done++;
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_string_end;
   logic [15:0] rsp_escaped_length;

   escape_scoreboard_type sb = new();
   bit     steady;
   bit     hold_request;
   int     hold_left;
   longint cycles = 0;

   xml_escape_encoder_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_run_last       (rsp_run_last),
      .rsp_string_end     (rsp_string_end),
      .rsp_escaped_length (rsp_escaped_length)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still pending",
                  cycles, sb.escaped_beats.size());
         $display("FAILURE");
         $finish;
      end
   end

   // Result side: check each accepted beat, then choose the stall for the next cycle.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_result(rsp_out_byte, rsp_run_last, rsp_string_end, rsp_escaped_length);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(0, 99) < 24);
         end
      end
   end

   task automatic send_byte(input logic [7:0] ch);
      while (!steady && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         req_in_byte <= 8'($urandom());
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= ch;
      do
         @(posedge clock);
      while (req_stall);
      sb.note_input(ch);
   endtask

   function automatic logic [7:0] pick_char(input int special_pct);
      if ($urandom_range(0, 99) < special_pct) begin
         case ($urandom_range(0, 6))
            0: return CHAR_AMP;
            1: return CHAR_LT;
            2: return CHAR_GT;
            3: return CHAR_QUOT;
            4: return CHAR_TAB;
            5: return CHAR_LF;
            default: return CHAR_CR;
         endcase
      end
      return 8'($urandom_range(1, 255));
   endfunction

   initial begin
      int items;
      int len;
      int special_pct;
      logic [7:0] directed_chars[$];

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_in_byte <= '0;
      rsp_stall <= 1'b0;
      steady = 1'b0;
      hold_request = 1'b0;
      hold_left = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty string first, then every entity and the byte extremes in one string.
      send_byte(CHAR_NUL);
      hold_request = 1'b1;
      directed_chars = '{CHAR_AMP, CHAR_LT, CHAR_GT, CHAR_QUOT, CHAR_TAB, CHAR_LF, CHAR_CR,
                         8'h01, 8'h7F, 8'h80, 8'hFF, 8'h41, CHAR_QUOT, 8'hAA, 8'h55};
      foreach (directed_chars[i])
         send_byte(directed_chars[i]);
      send_byte(CHAR_NUL);
      send_byte(CHAR_NUL);

      items = 0;
      while (items < RANDOM_ITEMS) begin
         steady = (items >= 100 && items < 170);
         if (items >= 200 && items < 215) hold_request = 1'b1;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
         special_pct = $urandom_range(0, 70);
         for (int i = 0; i < len; i++)
            send_byte(pick_char(special_pct));
         send_byte(CHAR_NUL);
         items += len + 1;
      end
      steady = 1'b0;
      // An unterminated tail still owes its escaped beats.
      repeat ($urandom_range(1, 5)) send_byte(pick_char(50));
      req_valid <= 1'b0;

      while (sb.escaped_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes and checked %0d escaped beats across %0d terminated strings,",
               sb.bytes_in, sb.beats_checked, sb.strings_done);
      $display("including every entity, empty strings, bytes up to 0xFF and long stalls.");
      if (sb.errors == 0 && sb.escaped_beats.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches, %0d beats never arrived", sb.errors,
                  sb.escaped_beats.size());
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/xesc_pkg.sv
hw/rtl/xesc_expand.sv
hw/rtl/xesc_count.sv
hw/rtl/xml_escape_encoder_top.sv
hw/rtl/xesc_checker.sv
test/xml_escape_encoder_top_tb.sv
